// ===== design/tsw_pkg.sv =====
// ----------------------------------------------------------------------------
// tsw_pkg - shared types and constants of the tcp sender window core
// item and result formats, state machine encodings and register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package tsw_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 1452;
    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam int unsigned NRES_MAX        = 48;
    localparam int unsigned RES_IW          = 6;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_ISN     = 2'd1;
    localparam logic [1:0] CFG_CAP     = 2'd2;

    typedef enum logic [2:0] {
        FN_WRITE = 3'd0,
        FN_END   = 3'd1,
        FN_FILL  = 3'd2,
        FN_ACK   = 3'd3,
        FN_TICK  = 3'd4,
        FN_EMPTY = 3'd5,
        FN_NONE  = 3'd6
    } t_func;

    typedef struct packed {
        t_func       func;
        logic [15:0] wcount;
        logic [31:0] ack;
        logic [15:0] win;
        logic [15:0] ms;
    } t_item;

    typedef struct packed {
        logic [31:0] seq;
        logic        syn;
        logic        fin;
        logic [10:0] plen;
        logic        retx;
    } t_res;

    typedef struct packed {
        logic              start;
        logic [RES_IW-1:0] n;
        logic [16:0]       flight;
        logic [7:0]        retx;
        logic [15:0]       accepted;
    } t_handoff;

    typedef enum logic [2:0] {
        E_IDLE, E_EXEC, E_ACK_D, E_ACK_CHK, E_ACK_CMP, E_ACK_WAIT, E_FILL, E_DONE
    } t_estate;

    typedef enum logic [1:0] {
        O_IDLE, O_RD, O_SHOW
    } t_ostate;

endpackage

`default_nettype wire

// ===== design/tcp_sender_window_retransmit_core.sv =====
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit_core - tcp sender window and retransmit engine
// flow: an input beat is taken in idle and worked in exec; write, end, tick, empty and
//   unknown codes go straight to done, a fill stays in its fill state while segments go
//   out, and an ack is unwrapped and checked, then dropped, or retires entries and fills
// each result beat is read, then shown; the next event starts after the last result beat
// one event is worked at a time; two more input beats queue in the front
// synchronous active-low reset empties queues and clears all sender state
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_sender_window_retransmit_core #(
    parameter int unsigned MAX_PAYLOAD = tsw_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    // input beats
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [87:0] i_s_tdata,  // func, write_count, ack_number, window_advert, elapsed_ms
    // result beats
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [87:0]      o_m_tdata,  // seq_out, syn_flag, fin_flag, payload_length,
                                         // in_flight_bytes, retx_count, accepted_count
    output logic [1:0]       o_m_tuser,  // seg_valid, is_retransmit
    output logic             o_m_tlast   // last_result
);

    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    logic [15:0] r_init_timeout;
    logic [31:0] r_isn;
    logic [15:0] r_capacity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_timeout <= 16'd1000;
            r_isn          <= 32'd0;
            r_capacity     <= 16'd65535;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                tsw_pkg::CFG_TIMEOUT: r_init_timeout <= i_cfg_wdata[15:0];
                tsw_pkg::CFG_ISN:     r_isn          <= i_cfg_wdata;
                tsw_pkg::CFG_CAP:     r_capacity     <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    tsw_pkg::t_item    item;
    logic              item_valid, item_take, out_busy, rw_en;
    tsw_pkg::t_handoff handoff;
    logic [tsw_pkg::RES_IW-1:0] rw_addr;
    tsw_pkg::t_res     rw_data;
    logic [CW-1:0]     qcount;
    logic [16:0]       flight;

    // front: accept and decode
    tsw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_take  (item_take)
    );

    // back: sender state and outstanding queue
    tsw_engine #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_init_timeout (r_init_timeout),
        .i_isn          (r_isn),
        .i_capacity     (r_capacity),
        .i_item         (item),
        .i_item_valid   (item_valid),
        .o_item_take    (item_take),
        .i_out_busy     (out_busy),
        .o_handoff      (handoff),
        .o_rw_en        (rw_en),
        .o_rw_addr      (rw_addr),
        .o_rw_data      (rw_data),
        .o_qcount       (qcount),
        .o_flight       (flight)
    );

    // result buffer and output beats
    tsw_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rw_en    (rw_en),
        .i_rw_addr  (rw_addr),
        .i_rw_data  (rw_data),
        .i_handoff  (handoff),
        .o_busy     (out_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // queue never overfills
    a_qcount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qcount <= CW'(QUEUE_DEPTH))
        else $error("outstanding queue overfilled");

    // an empty queue means nothing in flight
    a_flight_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (qcount == '0) |-> (flight == 17'd0))
        else $error("bytes in flight with empty queue");

    // a write never sends a segment
    a_write_noseg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[85:70] != 16'd0)) |-> !o_m_tuser[0])
        else $error("segment reported on write beat");

endmodule

`default_nettype wire

// ===== design/tsw_front.sv =====
// ----------------------------------------------------------------------------
// tsw_front - input side
// takes beats, decodes the event code and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module tsw_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [87:0]   i_s_tdata,
    output tsw_pkg::t_item     o_item,
    output logic               o_item_valid,
    input  wire logic          i_item_take
);

    tsw_pkg::t_item r_mem [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_cnt;
    tsw_pkg::t_item dec;
    logic           push, pop;

    always_comb begin
        unique case (i_s_tdata[2:0])
            3'd0:    dec.func = tsw_pkg::FN_WRITE;
            3'd1:    dec.func = tsw_pkg::FN_END;
            3'd2:    dec.func = tsw_pkg::FN_FILL;
            3'd3:    dec.func = tsw_pkg::FN_ACK;
            3'd4:    dec.func = tsw_pkg::FN_TICK;
            3'd5:    dec.func = tsw_pkg::FN_EMPTY;
            default: dec.func = tsw_pkg::FN_NONE;
        endcase
        dec.wcount = i_s_tdata[18:3];
        dec.ack    = i_s_tdata[50:19];
        dec.win    = i_s_tdata[66:51];
        dec.ms     = i_s_tdata[82:67];
    end

    assign o_s_tready   = (r_cnt != 2'd2);
    assign push         = i_s_tvalid && o_s_tready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = i_item_take && o_item_valid;
    assign o_item       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

// ===== design/tsw_engine.sv =====
// ----------------------------------------------------------------------------
// tsw_engine - sender state machine
// runs write, end, fill, ack, tick and empty events over the outstanding queue
// ----------------------------------------------------------------------------
`default_nettype none

module tsw_engine #(
    parameter int unsigned MAX_PAYLOAD = tsw_pkg::MAX_PAYLOAD_DEF,
    parameter int unsigned QUEUE_DEPTH = tsw_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned AW = $clog2(QUEUE_DEPTH),
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [15:0]                 i_init_timeout,
    input  wire logic [31:0]                 i_isn,
    input  wire logic [15:0]                 i_capacity,
    input  wire tsw_pkg::t_item              i_item,
    input  wire logic                        i_item_valid,
    output logic                             o_item_take,
    input  wire logic                        i_out_busy,
    output tsw_pkg::t_handoff                o_handoff,
    output logic                             o_rw_en,
    output logic [tsw_pkg::RES_IW-1:0]       o_rw_addr,
    output tsw_pkg::t_res                    o_rw_data,
    output logic [CW-1:0]                    o_qcount,
    output logic [16:0]                      o_flight
);

    localparam int unsigned TW = AW + 1;

    typedef struct packed {
        logic [63:0] start;
        logic [15:0] plen;
        logic        syn;
        logic        fin;
    } t_qent;

    tsw_pkg::t_estate r_state, n_state;
    tsw_pkg::t_item   r_item, n_item;
    logic [63:0] r_next, n_next, r_abs, n_abs;
    logic [16:0] r_flight, n_flight;
    logic        r_syn_sent, n_syn_sent, r_fin_sent, n_fin_sent, r_ended, n_ended;
    logic [15:0] r_lw, n_lw, r_buf, n_buf, r_acc, n_acc;
    logic [31:0] r_cto, n_cto, r_timer, n_timer, r_d, n_d;
    logic [7:0]  r_retx, n_retx;
    logic [AW-1:0] r_head, n_head, tail, head_inc;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [tsw_pkg::RES_IW-1:0] r_n, n_n;

    t_qent q_mem [QUEUE_DEPTH];
    t_qent r_qrd, q_wdata;
    logic  q_we;

    // fill datapath
    logic [16:0] f_win, f_room, f_t1, f_take, f_len;
    logic        f_syn, f_fin, f_go;
    // ack datapath
    logic [32:0] a_back;
    logic        a_ok, a_retire;
    logic [16:0] a_len;
    // tick and write datapath
    logic [32:0] t_sum;
    logic [31:0] t_new;
    logic [15:0] w_room, w_acc;
    logic [TW-1:0] tail_sum;

    assign o_item_take = (r_state == tsw_pkg::E_IDLE) && i_item_valid && !i_out_busy;
    assign o_qcount    = r_cnt;
    assign o_flight    = r_flight;
    assign o_rw_addr   = r_n;

    assign o_handoff.start    = (r_state == tsw_pkg::E_DONE);
    assign o_handoff.n        = r_n;
    assign o_handoff.flight   = r_flight;
    assign o_handoff.retx     = r_retx;
    assign o_handoff.accepted = r_acc;

    assign tail_sum = TW'(r_head) + TW'(r_cnt);
    assign tail     = (tail_sum >= TW'(QUEUE_DEPTH)) ? AW'(tail_sum - TW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);
    assign head_inc = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    // zero window counts as one
    assign f_win  = (r_lw == 16'd0) ? 17'd1 : {1'b0, r_lw};
    assign f_syn  = !r_syn_sent;
    assign f_room = f_win - r_flight - {16'd0, f_syn};
    assign f_t1   = (f_room < 17'(MAX_PAYLOAD)) ? f_room : 17'(MAX_PAYLOAD);
    assign f_take = (f_t1 > {1'b0, r_buf}) ? {1'b0, r_buf} : f_t1;
    // fin only when it still fits in the window
    assign f_fin  = !r_fin_sent && r_ended && ({1'b0, r_buf} == f_take) && (f_take < f_room);
    assign f_go   = (f_win > r_flight) && (r_n < tsw_pkg::RES_IW'(tsw_pkg::NRES_MAX))
                    && (r_cnt < CW'(QUEUE_DEPTH)) && (f_syn || (f_take != 17'd0) || f_fin);
    assign f_len  = f_take + {16'd0, f_syn} + {16'd0, f_fin};

    // ack unwrap against next seqno
    assign a_back   = 33'h1_0000_0000 - {1'b0, r_d};
    assign a_ok     = (r_d == 32'd0) || (r_d[31] && (r_next >= {31'd0, a_back}));
    assign a_len    = {1'b0, r_qrd.plen} + {16'd0, r_qrd.syn} + {16'd0, r_qrd.fin};
    assign a_retire = (r_cnt != '0) && !((r_qrd.start + {47'd0, a_len}) > r_abs);

    assign t_sum  = {1'b0, r_timer} + {17'd0, r_item.ms};
    assign t_new  = t_sum[32] ? 32'hFFFF_FFFF : t_sum[31:0];
    assign w_room = (!r_ended && (i_capacity > r_buf)) ? i_capacity - r_buf : 16'd0;
    assign w_acc  = (r_item.wcount < w_room) ? r_item.wcount : w_room;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsw_pkg::E_IDLE:     if (o_item_take) n_state = tsw_pkg::E_EXEC;
            tsw_pkg::E_EXEC: begin
                case (r_item.func)
                    tsw_pkg::FN_FILL: n_state = tsw_pkg::E_FILL;
                    tsw_pkg::FN_ACK:  n_state = tsw_pkg::E_ACK_D;
                    default:          n_state = tsw_pkg::E_DONE;
                endcase
            end
            tsw_pkg::E_ACK_D:    n_state = tsw_pkg::E_ACK_CHK;
            tsw_pkg::E_ACK_CHK:  n_state = a_ok ? tsw_pkg::E_ACK_CMP : tsw_pkg::E_DONE;
            tsw_pkg::E_ACK_CMP:  n_state = a_retire ? tsw_pkg::E_ACK_WAIT : tsw_pkg::E_FILL;
            tsw_pkg::E_ACK_WAIT: n_state = tsw_pkg::E_ACK_CMP;
            tsw_pkg::E_FILL:     n_state = (f_go && !f_fin) ? tsw_pkg::E_FILL : tsw_pkg::E_DONE;
            tsw_pkg::E_DONE:     n_state = tsw_pkg::E_IDLE;
            default:             n_state = tsw_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        n_item = r_item;  n_next = r_next;  n_abs = r_abs;  n_flight = r_flight;
        n_syn_sent = r_syn_sent;  n_fin_sent = r_fin_sent;  n_ended = r_ended;
        n_lw = r_lw;  n_buf = r_buf;  n_acc = r_acc;  n_cto = r_cto;  n_timer = r_timer;
        n_d = r_d;  n_retx = r_retx;  n_head = r_head;  n_cnt = r_cnt;  n_n = r_n;
        q_we = 1'b0;
        q_wdata = '{start: r_next, plen: f_take[15:0], syn: f_syn, fin: f_fin};
        o_rw_en = 1'b0;
        o_rw_data = '{seq: r_next[31:0] + i_isn, syn: f_syn, fin: f_fin,
                      plen: f_take[10:0], retx: 1'b0};
        unique case (r_state)
            tsw_pkg::E_IDLE: begin
                if (o_item_take) begin
                    n_item = i_item;
                    n_n    = '0;
                    n_acc  = 16'd0;
                end
            end
            tsw_pkg::E_EXEC: begin
                case (r_item.func)
                    tsw_pkg::FN_WRITE: begin
                        n_acc = w_acc;
                        n_buf = r_buf + w_acc;
                    end
                    tsw_pkg::FN_END: n_ended = 1'b1;
                    tsw_pkg::FN_TICK: begin
                        n_timer = t_new;
                        if ((r_cnt != '0) && (t_new >= r_cto)) begin
                            if (r_lw != 16'd0) begin
                                n_cto = r_cto[31] ? 32'hFFFF_FFFF : {r_cto[30:0], 1'b0};
                            end
                            n_timer   = 32'd0;
                            o_rw_en   = 1'b1;
                            o_rw_data = '{seq: r_qrd.start[31:0] + i_isn, syn: r_qrd.syn,
                                          fin: r_qrd.fin, plen: r_qrd.plen[10:0],
                                          retx: 1'b1};
                            n_n       = r_n + 1'b1;
                            if (r_retx != 8'hFF) n_retx = r_retx + 8'd1;
                        end
                    end
                    tsw_pkg::FN_EMPTY: begin
                        o_rw_en   = 1'b1;
                        o_rw_data = '{seq: r_next[31:0] + i_isn, syn: 1'b0, fin: 1'b0,
                                      plen: 11'd0, retx: 1'b0};
                        n_n       = r_n + 1'b1;
                    end
                    default: ;
                endcase
            end
            tsw_pkg::E_ACK_D:   n_d = r_item.ack - i_isn - r_next[31:0];
            tsw_pkg::E_ACK_CHK: n_abs = (r_d == 32'd0) ? r_next : r_next - {31'd0, a_back};
            tsw_pkg::E_ACK_CMP: begin
                if (a_retire) begin
                    n_flight = (r_flight >= a_len) ? r_flight - a_len : 17'd0;
                    n_head   = head_inc;
                    n_cnt    = r_cnt - 1'b1;
                    n_cto    = {16'd0, i_init_timeout};
                    n_timer  = 32'd0;
                end else begin
                    n_retx = 8'd0;
                    n_lw   = r_item.win;
                end
            end
            tsw_pkg::E_FILL: begin
                if (f_go) begin
                    n_syn_sent = 1'b1;
                    n_buf      = r_buf - f_take[15:0];
                    if (f_fin) n_fin_sent = 1'b1;
                    if (r_cnt == '0) begin
                        n_cto   = {16'd0, i_init_timeout};
                        n_timer = 32'd0;
                    end
                    q_we     = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_flight = r_flight + f_len;
                    n_next   = r_next + {47'd0, f_len};
                    o_rw_en  = 1'b1;
                    n_n      = r_n + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_we) q_mem[tail] <= q_wdata;
        r_qrd <= q_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_abs  <= n_abs;
        r_d    <= n_d;
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tsw_pkg::E_IDLE;
            r_next     <= 64'd0;
            r_flight   <= 17'd0;
            r_syn_sent <= 1'b0;
            r_fin_sent <= 1'b0;
            r_ended    <= 1'b0;
            r_lw       <= 16'd0;
            r_buf      <= 16'd0;
            r_cto      <= 32'd0;
            r_timer    <= 32'd0;
            r_retx     <= 8'd0;
            r_head     <= '0;
            r_cnt      <= '0;
            r_n        <= '0;
        end else begin
            r_state    <= n_state;
            r_next     <= n_next;
            r_flight   <= n_flight;
            r_syn_sent <= n_syn_sent;
            r_fin_sent <= n_fin_sent;
            r_ended    <= n_ended;
            r_lw       <= n_lw;
            r_buf      <= n_buf;
            r_cto      <= n_cto;
            r_timer    <= n_timer;
            r_retx     <= n_retx;
            r_head     <= n_head;
            r_cnt      <= n_cnt;
            r_n        <= n_n;
        end
    end

endmodule

`default_nettype wire

// ===== design/tsw_out.sv =====
// ----------------------------------------------------------------------------
// tsw_out - result side
// buffers the descriptors of one event and sends them with the final status
// ----------------------------------------------------------------------------
`default_nettype none

module tsw_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rw_en,
    input  wire logic [tsw_pkg::RES_IW-1:0]  i_rw_addr,
    input  wire tsw_pkg::t_res               i_rw_data,
    input  wire tsw_pkg::t_handoff           i_handoff,
    output logic                             o_busy,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [87:0]                      o_m_tdata,
    output logic [1:0]                       o_m_tuser,
    output logic                             o_m_tlast
);

    tsw_pkg::t_res   r_mem [tsw_pkg::NRES_MAX];
    tsw_pkg::t_res   r_rd;
    tsw_pkg::t_ostate r_state, n_state;
    logic [tsw_pkg::RES_IW-1:0] r_k, r_n;
    logic [16:0] r_flight;
    logic [7:0]  r_retx;
    logic [15:0] r_acc;
    logic        r_empty, last;

    assign last = r_empty || (r_k == r_n - 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsw_pkg::O_IDLE: if (i_handoff.start) n_state = tsw_pkg::O_RD;
            tsw_pkg::O_RD:   n_state = tsw_pkg::O_SHOW;
            tsw_pkg::O_SHOW: if (i_m_tready) n_state = last ? tsw_pkg::O_IDLE : tsw_pkg::O_RD;
            default:         n_state = tsw_pkg::O_IDLE;
        endcase
    end

    always_comb begin
        o_busy     = (r_state != tsw_pkg::O_IDLE);
        o_m_tvalid = (r_state == tsw_pkg::O_SHOW);
        o_m_tlast  = last;
        o_m_tuser  = {!r_empty && r_rd.retx, !r_empty};
        if (r_empty) begin
            o_m_tdata = {2'b00, r_acc, r_retx, r_flight, 11'd0, 1'b0, 1'b0, 32'd0};
        end else begin
            o_m_tdata = {2'b00, r_acc, r_retx, r_flight, r_rd.plen, r_rd.fin, r_rd.syn,
                         r_rd.seq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rw_en) r_mem[i_rw_addr] <= i_rw_data;
        if (r_state == tsw_pkg::O_RD) r_rd <= r_mem[r_k];
        if ((r_state == tsw_pkg::O_IDLE) && i_handoff.start) begin
            r_n      <= i_handoff.n;
            r_empty  <= (i_handoff.n == '0);
            r_flight <= i_handoff.flight;
            r_retx   <= i_handoff.retx;
            r_acc    <= i_handoff.accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsw_pkg::O_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tsw_pkg::O_IDLE) begin
                r_k <= '0;
            end else if ((r_state == tsw_pkg::O_SHOW) && i_m_tready) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/tcp_sender_window_retransmit_core_tb.sv =====
// ----------------------------------------------------------------------------
// tcp_sender_window_retransmit_core_tb - self-checking bench of the sender core
// drives event beats from a queue, predicts segment descriptors and status in
// a behavioural copy of the sender, and checks every result beat in order
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_sender_window_retransmit_core_tb;

    localparam int unsigned SEG_CAP   = 48;
    localparam int unsigned OQ_DEPTH  = 64;
    localparam int unsigned MSS       = 1452;
    localparam int unsigned CYCLE_LIM = 3000000;

    typedef struct {
        logic [2:0]  func;
        logic [15:0] wcount;
        logic [31:0] ack;
        logic [15:0] win;
        logic [15:0] ms;
    } t_event;

    typedef struct {
        longint unsigned start;
        int unsigned     plen;
        bit              syn;
        bit              fin;
        bit              retx;
    } t_seg;

    typedef struct {
        bit          seg_valid;
        logic [31:0] seq;
        bit          syn;
        bit          fin;
        logic [10:0] plen;
        bit          retx;
        bit          last;
        logic [16:0] flight;
        logic [7:0]  retx_cnt;
        logic [15:0] accepted;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [87:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [87:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    tcp_sender_window_retransmit_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // shadow of the sender state
    int unsigned     to_reg, isn_reg, cap_reg;
    longint unsigned next_seq;
    int unsigned     flight, last_win, cur_to, timer, retx_cnt, buffered;
    bit              syn_sent, fin_sent, ended;
    t_seg            outstanding[$];
    t_seg            sent_segs[$];

    t_event          pending_events[$];
    t_beat           expected_beats[$];
    t_event          cur_event;

    int unsigned     snd_idle_pct, rcv_idle_pct;
    int unsigned     stall_left;
    bit              stall_done;
    int unsigned     beats_seen;
    int unsigned     n_errors;
    int unsigned     cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // sender behaviour
    // ------------------------------------------------------------------------
    function automatic void send_window();
        int unsigned win, syn, room, take, fin;
        t_seg s;
        win = (last_win != 0) ? last_win : 1;   // zero window probes as one byte
        while (win > flight && sent_segs.size() < SEG_CAP && outstanding.size() < OQ_DEPTH) begin
            syn  = syn_sent ? 0 : 1;
            room = win - flight - syn;
            take = (room < MSS) ? room : MSS;
            if (take > buffered) take = buffered;
            // fin only when the whole segment including fin fits
            fin = (!fin_sent && ended && buffered == take && take + flight + syn < win) ? 1 : 0;
            if (syn + take + fin == 0) return;
            syn_sent = 1'b1;
            buffered -= take;
            if (fin != 0) fin_sent = 1'b1;
            if (outstanding.size() == 0) begin
                cur_to = to_reg;
                timer  = 0;
            end
            s.start = next_seq;
            s.plen  = take;
            s.syn   = syn[0];
            s.fin   = fin[0];
            s.retx  = 1'b0;
            outstanding.push_back(s);
            flight   += syn + take + fin;
            next_seq += syn + take + fin;
            sent_segs.push_back(s);
            if (fin != 0) break;
        end
    endfunction

    function automatic longint unsigned abs_ackno(logic [31:0] ack);
        logic [31:0] off, d;
        longint unsigned back;
        off = ack - isn_reg;
        d   = off - next_seq[31:0];
        if (d < 32'h8000_0000) return next_seq + d;
        back = 64'h1_0000_0000 - d;
        if (next_seq < back) return next_seq + d;
        return next_seq - back;
    endfunction

    function automatic void take_ack(logic [31:0] ack, logic [15:0] win);
        longint unsigned a;
        int unsigned len;
        a = abs_ackno(ack);
        if (a > next_seq) return;               // acks past what was sent are dropped
        while (outstanding.size() > 0) begin
            len = outstanding[0].syn + outstanding[0].plen + outstanding[0].fin;
            if (outstanding[0].start + len > a) break;
            flight = (flight >= len) ? flight - len : 0;
            void'(outstanding.pop_front());
            cur_to = to_reg;
            timer  = 0;
        end
        retx_cnt = 0;
        last_win = win;
        send_window();
    endfunction

    function automatic void take_tick(logic [15:0] ms);
        t_seg s;
        timer = (timer > 32'hFFFF_FFFF - ms) ? 32'hFFFF_FFFF : timer + ms;
        if (outstanding.size() > 0 && timer >= cur_to) begin
            // backoff only while the peer advertises space
            if (last_win > 0)
                cur_to = (cur_to > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : cur_to * 2;
            timer  = 0;
            s      = outstanding[0];
            s.retx = 1'b1;
            sent_segs.push_back(s);
            if (retx_cnt < 255) retx_cnt++;
        end
    endfunction

    // work out every result beat of one accepted event
    function automatic void predict_event(t_event ev);
        int unsigned room, acc, n;
        t_beat b;
        t_seg s;
        acc = 0;
        sent_segs.delete();
        case (ev.func)
            tsw_pkg::FN_WRITE: begin
                room = (!ended && cap_reg > buffered) ? cap_reg - buffered : 0;
                acc  = (ev.wcount < room) ? ev.wcount : room;
                buffered += acc;
            end
            tsw_pkg::FN_END:   ended = 1'b1;
            tsw_pkg::FN_FILL:  send_window();
            tsw_pkg::FN_ACK:   take_ack(ev.ack, ev.win);
            tsw_pkg::FN_TICK:  take_tick(ev.ms);
            tsw_pkg::FN_EMPTY: begin
                s = '{start: next_seq, plen: 0, syn: 1'b0, fin: 1'b0, retx: 1'b0};
                sent_segs.push_back(s);
            end
            default: ;
        endcase
        n = (sent_segs.size() > 0) ? sent_segs.size() : 1;
        for (int k = 0; k < n; k++) begin
            b = '{default: '0};
            if (sent_segs.size() > 0) begin
                b.seg_valid = 1'b1;
                b.seq       = sent_segs[k].start[31:0] + isn_reg;
                b.syn       = sent_segs[k].syn;
                b.fin       = sent_segs[k].fin;
                b.plen      = sent_segs[k].plen[10:0];
                b.retx      = sent_segs[k].retx;
            end
            b.last     = (k == n - 1);
            b.flight   = flight[16:0];
            b.retx_cnt = retx_cnt[7:0];
            b.accepted = acc[15:0];
            expected_beats.push_back(b);
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: one event beat held until accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) predict_event(cur_event);
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    cur_event  = pending_events.pop_front();
                    // func, write_count, ack_number, window_advert, elapsed_ms from bit 0
                    i_s_tdata  <= {5'd0, cur_event.ms, cur_event.win, cur_event.ack,
                                   cur_event.wcount, cur_event.func};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor with a long one-off hold-off to back the core up
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beat e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end else begin
                    e = expected_beats.pop_front();
                    if (o_m_tuser[0] !== e.seg_valid) begin
                        $error("seg_valid exp %0d got %0d", e.seg_valid, o_m_tuser[0]);
                        n_errors++;
                    end
                    if (o_m_tdata[31:0] !== e.seq) begin
                        $error("seq_out exp %h got %h", e.seq, o_m_tdata[31:0]);
                        n_errors++;
                    end
                    if (o_m_tdata[32] !== e.syn) begin
                        $error("syn_flag exp %0d got %0d", e.syn, o_m_tdata[32]);
                        n_errors++;
                    end
                    if (o_m_tdata[33] !== e.fin) begin
                        $error("fin_flag exp %0d got %0d", e.fin, o_m_tdata[33]);
                        n_errors++;
                    end
                    if (o_m_tdata[44:34] !== e.plen) begin
                        $error("payload_length exp %0d got %0d", e.plen, o_m_tdata[44:34]);
                        n_errors++;
                    end
                    if (o_m_tuser[1] !== e.retx) begin
                        $error("is_retransmit exp %0d got %0d", e.retx, o_m_tuser[1]);
                        n_errors++;
                    end
                    if (o_m_tlast !== e.last) begin
                        $error("last_result exp %0d got %0d", e.last, o_m_tlast);
                        n_errors++;
                    end
                    if (o_m_tdata[61:45] !== e.flight) begin
                        $error("in_flight_bytes exp %0d got %0d", e.flight, o_m_tdata[61:45]);
                        n_errors++;
                    end
                    if (o_m_tdata[69:62] !== e.retx_cnt) begin
                        $error("retx_count exp %0d got %0d", e.retx_cnt, o_m_tdata[69:62]);
                        n_errors++;
                    end
                    if (o_m_tdata[85:70] !== e.accepted) begin
                        $error("accepted_count exp %0d got %0d", e.accepted,
                               o_m_tdata[85:70]);
                        n_errors++;
                    end
                end
            end
            // long hold-off once some traffic has passed
            if (!stall_done && beats_seen == 60) begin
                stall_done = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIM) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic reg_write(logic [1:0] addr, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            tsw_pkg::CFG_TIMEOUT: to_reg  = data[15:0];
            tsw_pkg::CFG_ISN:     isn_reg = data;
            tsw_pkg::CFG_CAP:     cap_reg = data[15:0];
            default: ;
        endcase
    endtask

    task automatic push_ev(logic [2:0] f, logic [15:0] wc, logic [31:0] ack,
                           logic [15:0] win, logic [15:0] ms);
        t_event ev;
        ev = '{func: f, wcount: wc, ack: ack, win: win, ms: ms};
        pending_events.push_back(ev);
    endtask

    // keep the queue short so acks are drawn from a fresh view of the sender
    task automatic push_paced(t_event ev);
        while (pending_events.size() > 2) @(posedge i_clk);
        pending_events.push_back(ev);
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || i_s_tvalid || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic t_event rand_event();
        t_event ev;
        longint unsigned base, a;
        int unsigned r;
        r = $urandom_range(99);
        ev.wcount = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        ev.ms     = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * to_reg));
        case ($urandom_range(2))
            0: ev.win = 16'($urandom);
            1: ev.win = 16'($urandom_range(0, 3000));
            default: ev.win = 16'($urandom_range(0, 8));
        endcase
        base = (outstanding.size() > 0) ? outstanding[0].start : next_seq;
        case ($urandom_range(9))
            0: a = next_seq + $urandom_range(1, 2000);               // ahead of sent data
            1: a = {$urandom, $urandom};                              // noise
            default: a = base + $urandom_range(0, int'(next_seq - base));
        endcase
        ev.ack = a[31:0] + isn_reg;
        if (r < 22)      ev.func = tsw_pkg::FN_WRITE;
        else if (r < 44) ev.func = tsw_pkg::FN_FILL;
        else if (r < 74) ev.func = tsw_pkg::FN_ACK;
        else if (r < 92) ev.func = tsw_pkg::FN_TICK;
        else if (r < 97) ev.func = tsw_pkg::FN_EMPTY;
        else if (r < 99) ev.func = tsw_pkg::FN_NONE;
        else             ev.func = 3'(tsw_pkg::FN_NONE) + 3'd1;   // unused code
        return ev;
    endfunction

    task automatic random_run(int unsigned n);
        for (int i = 0; i < n; i++) push_paced(rand_event());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        to_reg = 1000; isn_reg = 0; cap_reg = 65535;
        next_seq = 0; flight = 0; last_win = 0; cur_to = 0; timer = 0;
        retx_cnt = 0; buffered = 0; syn_sent = 0; fin_sent = 0; ended = 0;
        n_errors = 0; beats_seen = 0; cycles = 0; stall_left = 0; stall_done = 0;
        snd_idle_pct = 28;
        rcv_idle_pct = 69;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // phase one: tiny timeout, sequence numbers that wrap soon
        reg_write(tsw_pkg::CFG_TIMEOUT, 32'd1);
        reg_write(tsw_pkg::CFG_ISN, 32'hFFFF_FFF0);
        reg_write(tsw_pkg::CFG_CAP, 32'd65535);

        // directed opening
        push_ev(tsw_pkg::FN_EMPTY, 0, 0, 0, 0);                  // empty segment before syn
        push_ev(tsw_pkg::FN_TICK, 0, 0, 0, 16'hFFFF);            // tick with nothing outstanding
        push_ev(tsw_pkg::FN_FILL, 0, 0, 0, 0);                   // syn through a zero window
        push_ev(tsw_pkg::FN_ACK, 0, 32'hFFFF_FFF0 + 5, 16'hFFFF, 0);  // ack past next seqno
        push_ev(tsw_pkg::FN_ACK, 0, 32'hFFFF_FFF1, 16'd0, 0);    // syn acked, zero window
        push_ev(tsw_pkg::FN_WRITE, 16'hFFFF, 0, 0, 0);
        push_ev(tsw_pkg::FN_WRITE, 16'd0, 0, 0, 0);
        push_ev(tsw_pkg::FN_WRITE, 16'd7, 0, 0, 0);              // capacity already full
        push_ev(tsw_pkg::FN_FILL, 0, 0, 0, 0);                   // one-byte window probe
        push_ev(tsw_pkg::FN_TICK, 0, 0, 0, 16'd1);               // retransmit without backoff
        push_ev(tsw_pkg::FN_TICK, 0, 0, 0, 16'd0);
        push_ev(tsw_pkg::FN_ACK, 0, 32'hFFFF_FFF2, 16'hFFFF, 0); // big window, long burst
        push_ev(tsw_pkg::FN_TICK, 0, 0, 0, 16'hFFFF);            // retransmit with backoff
        push_ev(tsw_pkg::FN_TICK, 0, 0, 0, 16'hFFFF);
        push_ev(tsw_pkg::FN_ACK, 0, 32'hFFFF_FFFF, 16'hFFFF, 0);
        push_ev(tsw_pkg::FN_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        push_ev(3'(tsw_pkg::FN_NONE) + 3'd1, 0, 0, 0, 0);
        push_ev(tsw_pkg::FN_EMPTY, 0, 0, 0, 0);
        random_run(50);
        drain();

        // phase two: longest timeout, one-byte capacity
        snd_idle_pct = 69;
        rcv_idle_pct = 28;
        reg_write(tsw_pkg::CFG_TIMEOUT, 32'd65535);
        reg_write(tsw_pkg::CFG_ISN, $urandom);
        reg_write(tsw_pkg::CFG_CAP, 32'd1);
        random_run(90);
        drain();

        // phase three: no idling; queue fill, then end of stream
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        reg_write(tsw_pkg::CFG_TIMEOUT, 32'd200);
        reg_write(tsw_pkg::CFG_ISN, 32'd0);
        reg_write(tsw_pkg::CFG_CAP, 32'd40000);
        begin
            t_event ev;
            // everything acked and a wide window, then single-byte segments
            ev = '{func: tsw_pkg::FN_ACK, wcount: 0, ack: next_seq[31:0] + isn_reg,
                   win: 16'hFFFF, ms: 0};
            push_paced(ev);
            for (int i = 0; i < 70; i++) begin
                push_paced('{func: tsw_pkg::FN_WRITE, wcount: 16'd1, ack: 0, win: 0, ms: 0});
                push_paced('{func: tsw_pkg::FN_FILL, wcount: 0, ack: 0, win: 0, ms: 0});
            end
            random_run(40);
            push_paced('{func: tsw_pkg::FN_END, wcount: 0, ack: 0, win: 0, ms: 0});
            push_paced('{func: tsw_pkg::FN_WRITE, wcount: 16'd100, ack: 0, win: 0, ms: 0});
            random_run(40);
        end
        drain();

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
